>>> rtl/adcbsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcbsf_pkg
// Shared constants and types for the ADC block average / slew filter.
// ----------------------------------------------------------------------------
package adcbsf_pkg;

  localparam int RING_DEPTH  = 16;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int BLOCK_LEN   = 256;
  localparam int BLOCK_AW    = $clog2(BLOCK_LEN);
  localparam int SAMPLE_BITS = 12;
  localparam int SUM_BITS    = SAMPLE_BITS + BLOCK_AW;
  localparam int WCNT_BITS   = 8;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FILTER = 1'b1
  } op_t;

  typedef logic [SAMPLE_BITS-1:0] value_t;

  typedef struct packed {
    value_t tracker;
    value_t average;
    value_t entry;
  } step_in_t;

endpackage

>>> rtl/adcbsf_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcbsf_step
// Compare-and-step unit: reload a zero tracker from the average, then move
// it one count toward the ring entry.
// ----------------------------------------------------------------------------
module adcbsf_step
  import adcbsf_pkg::*;
(
  input  step_in_t step_in,
  output value_t   tracker_next
);

  value_t base;

  always_comb begin
    base = (step_in.tracker == '0) ? step_in.average : step_in.tracker;
    if (step_in.entry < base) begin
      tracker_next = base - value_t'(1);
    end else if (step_in.entry > base) begin
      tracker_next = base + value_t'(1);
    end else begin
      tracker_next = base;
    end
  end

endmodule

>>> rtl/adc_block_average_slew_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_block_average_slew_filter_core
// Sample word: result registered the cycle after accept; next word accepted
//   the following cycle when the result is taken or the result slot is free.
// Filter word: all RING_DEPTH (16) ring entries, one ring entry per cycle through the
//   shared compare-and-step unit, then the result is registered.
// Reset (rst, synchronous): clears ring, counters, sum, average, tracker,
//   ready and the result slot.
// ----------------------------------------------------------------------------
module adc_block_average_slew_filter_core
  import adcbsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] block_average,
  output logic [SAMPLE_BITS-1:0] tracked_value,
  output logic                   ready_flag
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                state;
  logic   [RING_AW-1:0]  idx;
  value_t                ring [RING_DEPTH];
  logic   [WCNT_BITS-1:0] wcnt;
  logic   [BLOCK_AW-1:0] blk_cnt;
  logic   [SUM_BITS-1:0] sum;
  value_t                avg;
  value_t                tracker;
  logic                  ready;

  logic                   in_acc;
  logic                   out_free;
  logic                   walk_last;
  logic                   res_post;
  logic   [WCNT_BITS-1:0] wcnt_next;
  logic   [SUM_BITS-1:0]  sum_next;
  logic                   blk_last;
  step_in_t               step_in;
  value_t                 tracker_next;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state == ST_WALK) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign walk_last = (state == ST_WALK) && (idx == RING_AW'(RING_DEPTH - 1));
  assign res_post  = (in_acc && (op_t'(op) == OP_SAMPLE)) || walk_last;
  assign wcnt_next = wcnt + WCNT_BITS'(1);
  assign sum_next  = sum + SUM_BITS'(sample);
  assign blk_last  = (blk_cnt == BLOCK_AW'(BLOCK_LEN - 1));

  assign step_in.tracker = tracker;
  assign step_in.average = avg;
  assign step_in.entry   = ring[idx];

  adcbsf_step u_step (
    .step_in      (step_in),
    .tracker_next (tracker_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      wcnt          <= '0;
      blk_cnt       <= '0;
      sum           <= '0;
      avg           <= '0;
      tracker       <= '0;
      ready         <= 1'b0;
      out_valid     <= 1'b0;
      block_average <= '0;
      tracked_value <= '0;
      ready_flag    <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (res_post) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (op_t'(op) == OP_FILTER) begin
              state <= ST_WALK;
              idx   <= '0;
            end else begin
              ring[wcnt[RING_AW-1:0]] <= sample;
              wcnt                    <= wcnt_next;
              if ({1'b0, wcnt_next} > (WCNT_BITS + 1)'(RING_DEPTH)) begin
                ready <= 1'b1;
              end
              if (blk_last) begin
                blk_cnt       <= '0;
                sum           <= '0;
                avg           <= sum_next[BLOCK_AW +: SAMPLE_BITS];
                block_average <= sum_next[BLOCK_AW +: SAMPLE_BITS];
              end else begin
                blk_cnt       <= blk_cnt + BLOCK_AW'(1);
                sum           <= sum_next;
                block_average <= avg;
              end
              tracked_value <= tracker;
              ready_flag    <= ready ||
                               ({1'b0, wcnt_next} > (WCNT_BITS + 1)'(RING_DEPTH));
            end
          end
        end
        ST_WALK: begin
          tracker <= tracker_next;
          idx     <= idx + RING_AW'(1);
          if (walk_last) begin
            state         <= ST_IDLE;
            ready         <= 1'b0;
            block_average <= avg;
            tracked_value <= tracker_next;
            ready_flag    <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_filter_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op_t'(op) == OP_FILTER) |=> (state == ST_WALK))
    else $error("filter word did not start a ring walk");

  a_walk_end_result: assert property (@(posedge clk) disable iff (rst)
    walk_last |=> (out_valid && !ready_flag && !ready))
    else $error("ring walk end did not post result with ready cleared");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (idx == '0))
    else $error("walk index not parked at zero while idle");

  a_walk_holds_ring: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |=> $stable(wcnt))
    else $error("write counter moved during ring walk");
`endif

endmodule
